// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/hsc_pkg.sv
// Types, constants and position helpers for the Hamming SEC codec
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

  localparam int CODE_W = 64;
  localparam int DATA_W = 57;
  localparam int POS_W  = 7;

  localparam logic [POS_W-1:0] MIN_CODE_LENGTH   = 7'd3;
  localparam logic [POS_W-1:0] RESET_CODE_LENGTH = 7'd7;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // position p (1-based) holds a parity bit when p is a power of two
  function automatic logic is_pow2(int unsigned p);
    return (p & (p - 1)) == 0;
  endfunction

  function automatic int unsigned floor_log2(int unsigned p);
    int unsigned r;
    r = 0;
    for (int unsigned v = p; v > 1; v = v >> 1) begin
      r = r + 1;
    end
    return r;
  endfunction

  // data bit index carried at non-parity position p
  function automatic int unsigned data_index(int unsigned p);
    return p - floor_log2(p) - 2;
  endfunction

  // codeword bits whose position has syndrome bit b set
  function automatic logic [CODE_W-1:0] syndrome_mask(int unsigned b);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < CODE_W; i++) begin
      m[i] = (((i + 1) >> b) & 1) != 0;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hamming_sec_codec.sv
// Hamming single-error-correcting codec, top level
//
// One item per clock cycle. An item is taken at a rising edge with start high
// and busy low; busy is high only while rst is asserted. Each item passes an
// input register and then a result register: the result is on the output
// ports, with done high, once the result register has taken it; done
// is high for a single cycle per item. The
// receiver cannot stall, so results must be
// captured when done is high. Operation 0 encodes data_in into code_out
// (other result fields zero); operation 1 decodes code_in, corrects one bit
// when the syndrome points inside the codeword, and returns data_out with the
// flags (code_out zero). The codeword length n is set through cfg_we /
// cfg_wdata, clamped to 3..MAX_CODE_LENGTH, resets to 7, and must only be
// written while no item is in flight. Codeword bit i-1 is position i; parity
// sits at power-of-two positions, data fills the rest in ascending order.
// A syndrome above n raises syndrome_out_of_range and leaves data uncorrected.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hamming_sec_codec #(
  parameter int MAX_CODE_LENGTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // item handshake
  input  wire logic                         start,
  output logic                              busy,
  // input fields
  input  wire logic                         operation,
  input  wire logic [hsc_pkg::DATA_W-1:0]   data_in,
  input  wire logic [hsc_pkg::CODE_W-1:0]   code_in,
  // code length register
  input  wire logic                         cfg_we,
  input  wire logic [hsc_pkg::POS_W-1:0]    cfg_wdata,
  // result
  output logic                              done,
  output logic      [hsc_pkg::CODE_W-1:0]   code_out,
  output logic      [hsc_pkg::DATA_W-1:0]   data_out,
  output logic                              error_corrected,
  output logic      [hsc_pkg::POS_W-1:0]    error_position,
  output logic                              syndrome_out_of_range
);

  localparam int CW = hsc_pkg::CODE_W;
  localparam int DW = hsc_pkg::DATA_W;
  localparam int PW = hsc_pkg::POS_W;
  localparam logic [PW-1:0] MAX_LEN = PW'(MAX_CODE_LENGTH);

  // ---------------------------------------------------------------------------
  // Code length register, clamped on write
  // ---------------------------------------------------------------------------
  logic [PW-1:0] code_length;
  logic [PW-1:0] code_length_next;

  always_comb begin
    if (cfg_wdata < hsc_pkg::MIN_CODE_LENGTH) begin
      code_length_next = hsc_pkg::MIN_CODE_LENGTH;
    end else if (cfg_wdata > MAX_LEN) begin
      code_length_next = MAX_LEN;
    end else begin
      code_length_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= hsc_pkg::RESET_CODE_LENGTH;
    end else if (cfg_we) begin
      code_length <= code_length_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  assign busy = rst;

  logic          in_valid;
  hsc_pkg::op_t  in_op;
  logic [DW-1:0] in_data;
  logic [CW-1:0] in_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op   <= hsc_pkg::op_t'(operation);
      in_data <= data_in;
      in_code <= code_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Codec datapath
  // ---------------------------------------------------------------------------
  logic [CW-1:0] len_mask;     // positions 1..n
  logic [CW-1:0] scattered;    // data placed at non-parity positions
  logic [CW-1:0] code_masked;
  logic [CW-1:0] syn_in;
  logic [PW-1:0] syndrome;
  logic [CW-1:0] flip;
  logic [CW-1:0] corrected;
  logic [CW-1:0] encoded;
  logic [DW-1:0] extracted;
  logic          in_range;
  logic          out_of_range;

  for (genvar i = 0; i < CW; i++) begin : g_pos
    assign len_mask[i] = PW'(i) < code_length;
    assign flip[i]     = (syndrome == PW'(i + 1)) && len_mask[i];
    if (hsc_pkg::is_pow2(i + 1)) begin : g_parity
      localparam int B = hsc_pkg::floor_log2(i + 1);
      assign scattered[i] = 1'b0;
      assign encoded[i]   = syndrome[B] && len_mask[i];
    end else begin : g_data
      localparam int J = hsc_pkg::data_index(i + 1);
      assign scattered[i] = in_data[J] && len_mask[i];
      assign encoded[i]   = scattered[i];
      assign extracted[J] = corrected[i];
    end
  end

  assign code_masked = in_code & len_mask;
  // one syndrome unit serves both directions
  assign syn_in      = (in_op == hsc_pkg::OP_DECODE) ? code_masked : scattered;
  assign corrected   = code_masked ^ flip;

  hsc_syndrome u_syndrome (
    .code     (syn_in),
    .syndrome (syndrome)
  );

  assign in_range     = (syndrome != '0) && (syndrome <= code_length);
  assign out_of_range = syndrome > code_length;

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (in_op == hsc_pkg::OP_DECODE) begin
        code_out              <= '0;
        data_out              <= extracted;
        error_corrected       <= in_range;
        error_position        <= syndrome;
        syndrome_out_of_range <= out_of_range;
      end else begin
        code_out              <= encoded;
        data_out              <= '0;
        error_corrected       <= 1'b0;
        error_position        <= '0;
        syndrome_out_of_range <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_item_taken, clk, rst, start && !busy, in_valid, "item not taken")
  `ASSERT_NEXT(a_item_gives_result, clk, rst, in_valid, done, "item lost")
  `ASSERT_IMPLIES(a_result_has_item, clk, rst, done, $past(in_valid), "spurious result")
  `ASSERT_ALWAYS(a_flags_exclusive, clk, rst, !(done && error_corrected && syndrome_out_of_range), "both error flags set")
  `ASSERT_IMPLIES(a_corr_in_range, clk, rst, done && error_corrected, (error_position != '0) && (error_position <= code_length), "correction outside codeword")

endmodule

`default_nettype wire

// File: hw/rtl/hsc_syndrome.sv
// Syndrome generator: XOR of the positions of all set codeword bits
`timescale 1ns / 1ps
`default_nettype none

module hsc_syndrome (
  input  wire logic [hsc_pkg::CODE_W-1:0] code,
  output logic      [hsc_pkg::POS_W-1:0]  syndrome
);

  always_comb begin
    for (int b = 0; b < hsc_pkg::POS_W; b++) begin
      syndrome[b] = ^(code & hsc_pkg::syndrome_mask(b));
    end
  end

endmodule

`default_nettype wire
